// ===== src/llrg_pkg.sv =====
// Shared types, constants and helper functions for the light level ramp generator.
// Used by light_level_ramp_generator_core and its checker.
`timescale 1ns / 1ps
`default_nettype none

package llrg_pkg;

    localparam int LVL_W        = 16;
    localparam int TIME_W       = 26;
    localparam int DLY_W        = 11;
    localparam int DVS_W        = 16;
    localparam int ACT_W        = 2;
    localparam int STEP_SIZE_DEF = 255;

    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 80;

    localparam logic [ACT_W-1:0] ACT_SET  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_TICK = 2'd1;
    localparam logic [ACT_W-1:0] ACT_GET  = 2'd2;
    localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;

    localparam logic CFG_RANGE_MIN = 1'b0;
    localparam logic CFG_RANGE_MAX = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_STEPS,
        S_DIV,
        S_DIV_WAIT,
        S_SET_FIN,
        S_TICK,
        S_FIRE,
        S_RESP
    } t_state;

    // Zero stays zero; at or below min gives min; otherwise limit to max.
    function automatic logic [LVL_W-1:0] clamp_level(
        input logic [LVL_W-1:0] v,
        input logic [LVL_W-1:0] rmin,
        input logic [LVL_W-1:0] rmax
    );
        logic [LVL_W-1:0] res;
        if (v == '0) begin
            res = '0;
        end else if (v <= rmin) begin
            res = rmin;
        end else if (v > rmax) begin
            res = rmax;
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== src/llrg_div.sv =====
// Restoring bit-serial unsigned divider, one quotient bit per cycle.
// Depends on llrg_pkg only through the widths handed down by the top level.
`timescale 1ns / 1ps
`default_nettype none

module llrg_div #(
    parameter int DVD_W = 26,
    parameter int DVS_W = 16
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_start,
    input  wire [DVD_W-1:0]  i_dividend,
    input  wire [DVS_W-1:0]  i_divisor,
    output logic             o_busy,
    output logic [DVD_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [DVD_W-1:0] r_quo, n_quo;
    logic [DVS_W-1:0] r_rem, n_rem;
    logic [DVS_W-1:0] r_dvs, n_dvs;
    logic [DVS_W:0]   shifted;
    logic             fits;

    assign shifted = {r_rem, r_quo[DVD_W-1]};
    assign fits    = shifted >= {1'b0, r_dvs};

    always_comb begin
        n_cnt = r_cnt;
        n_quo = r_quo;
        n_rem = r_rem;
        n_dvs = r_dvs;
        if (i_start) begin
            n_cnt = CNT_W'(DVD_W);
            n_quo = i_dividend;
            n_rem = '0;
            n_dvs = i_divisor;
        end else if (r_cnt != '0) begin
            n_cnt = r_cnt - CNT_W'(1);
            n_quo = {r_quo[DVD_W-2:0], fits};
            n_rem = fits ? DVS_W'(shifted - {1'b0, r_dvs}) : shifted[DVS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_busy     = r_cnt != '0;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

// ===== src/light_level_ramp_generator_core.sv =====
// Top level of the light level ramp generator: sequencer, ramp state and output register.
// Depends on llrg_pkg and llrg_div.
`timescale 1ns / 1ps
`default_nettype none

// One transaction in, at most one out; the block takes one item at a time and
// holds s_axis_tready low while it works. A get goes straight to the response
// state, a tick passes through the tick state and, when it fires a ramp step,
// the fire state; a set first takes the step count from a reciprocal multiply
// of the level gap, then the transition time goes once through the serial
// divider before the set is finished. A set with a gap below STEP_SIZE skips
// the divider. The finished result sits in an output register, so the next item
// is taken while it waits for the downstream side; a result still waiting there
// holds the block in its last state. Action code three is consumed without a
// result.
module light_level_ramp_generator_core #(
    parameter int STEP_SIZE = llrg_pkg::STEP_SIZE_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // [1:0] action
    input  wire [llrg_pkg::ACT_W-1:0]        s_axis_tuser,
    // [15:0] level, [41:16] trans_time_ms, [52:42] delay_ms, [55:53] zero
    input  wire [llrg_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    // [15:0] drive_level, [16] drive_write, [32:17] now_level, [48:33] goal_level,
    // [74:49] remaining_ms, [75] ramp_done, [79:76] zero
    output logic [llrg_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    input  wire                              i_cfg_we,
    input  wire                              i_cfg_idx,
    input  wire [llrg_pkg::LVL_W-1:0]        i_cfg_wdata
);

    localparam int LVL_W  = llrg_pkg::LVL_W;
    localparam int TIME_W = llrg_pkg::TIME_W;
    localparam int DLY_W  = llrg_pkg::DLY_W;
    localparam int DVS_W  = llrg_pkg::DVS_W;

    // gap / STEP_SIZE == (gap * ceil(2^RCP_SH / STEP_SIZE)) >> RCP_SH for any 16-bit gap
    localparam int     RCP_SH  = LVL_W + $clog2(STEP_SIZE);
    localparam int     RCP_W   = LVL_W + 1;
    localparam int     PROD_W  = RCP_SH + LVL_W;
    localparam longint RCP_VAL = ((longint'(1) <<< RCP_SH) + longint'(STEP_SIZE) - 1)
                                 / longint'(STEP_SIZE);
    localparam logic [RCP_W-1:0] STEP_RCP = RCP_W'(RCP_VAL);

    llrg_pkg::t_state r_state, n_state;

    logic [llrg_pkg::ACT_W-1:0] r_act;
    logic [LVL_W-1:0]  r_lvl, r_now, r_goal, r_rmin, r_rmax, r_steps;
    logic [TIME_W-1:0] r_ttime, r_period, r_tleft, r_wait;
    logic [DLY_W-1:0]  r_delay;
    logic              r_active, r_wrote, r_done;
    logic              r_out_valid;
    logic [llrg_pkg::OUT_DATA_W-1:0] r_out_data;

    logic              in_fire, out_load, div_start, div_busy;
    logic [TIME_W-1:0] div_dvd, div_quo, tleft_sub;
    logic [DVS_W-1:0]  div_dvs;
    logic [LVL_W-1:0]  gap_set, gap_goal, drive_val, now_out, steps_calc;
    logic [PROD_W-1:0] step_prod;
    logic              fire_end;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign gap_set  = (r_lvl > r_now) ? r_lvl - r_now : r_now - r_lvl;
    assign gap_goal = (r_goal > r_now) ? r_goal - r_now : r_now - r_goal;
    assign tleft_sub = (r_tleft > r_period) ? r_tleft - r_period : '0;
    assign fire_end = (r_tleft <= r_period) || (gap_goal <= LVL_W'(STEP_SIZE));

    assign step_prod  = PROD_W'(gap_set) * PROD_W'(STEP_RCP);
    assign steps_calc = step_prod[RCP_SH +: LVL_W];

    // Serial divider: transition time by the step count.
    assign div_dvd = r_ttime;
    assign div_dvs = r_steps;

    llrg_div #(
        .DVD_W (TIME_W),
        .DVS_W (DVS_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_busy     (div_busy),
        .o_quotient (div_quo)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            llrg_pkg::S_IDLE: begin
                if (in_fire) begin
                    case (s_axis_tuser)
                        llrg_pkg::ACT_SET:  n_state = llrg_pkg::S_STEPS;
                        llrg_pkg::ACT_TICK: n_state = llrg_pkg::S_TICK;
                        llrg_pkg::ACT_GET:  n_state = llrg_pkg::S_RESP;
                        default:            n_state = llrg_pkg::S_IDLE;
                    endcase
                end
            end
            llrg_pkg::S_STEPS: begin
                n_state = (steps_calc == '0) ? llrg_pkg::S_SET_FIN : llrg_pkg::S_DIV;
            end
            llrg_pkg::S_DIV:  n_state = llrg_pkg::S_DIV_WAIT;
            llrg_pkg::S_DIV_WAIT: begin
                if (!div_busy) begin
                    n_state = llrg_pkg::S_SET_FIN;
                end
            end
            llrg_pkg::S_SET_FIN: n_state = llrg_pkg::S_RESP;
            llrg_pkg::S_TICK: begin
                if (r_active && r_wait <= TIME_W'(1)) begin
                    n_state = llrg_pkg::S_FIRE;
                end else begin
                    n_state = llrg_pkg::S_RESP;
                end
            end
            llrg_pkg::S_FIRE: n_state = llrg_pkg::S_RESP;
            llrg_pkg::S_RESP: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_state = llrg_pkg::S_IDLE;
                end
            end
            default: n_state = llrg_pkg::S_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        s_axis_tready = 1'b0;
        div_start     = 1'b0;
        out_load      = 1'b0;
        unique case (r_state)
            llrg_pkg::S_IDLE:  s_axis_tready = 1'b1;
            llrg_pkg::S_DIV:   div_start = 1'b1;
            llrg_pkg::S_RESP:  out_load = !r_out_valid || m_axis_tready;
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= llrg_pkg::S_IDLE;
            r_now    <= '0;
            r_goal   <= '0;
            r_period <= '0;
            r_tleft  <= '0;
            r_wait   <= '0;
            r_active <= 1'b0;
            r_rmin   <= LVL_W'(1);
            r_rmax   <= '1;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    llrg_pkg::CFG_RANGE_MIN: r_rmin <= i_cfg_wdata;
                    default:                 r_rmax <= i_cfg_wdata;
                endcase
            end
            case (r_state)
                llrg_pkg::S_STEPS: begin
                    if (steps_calc == '0) begin
                        r_period <= '0;
                    end
                end
                llrg_pkg::S_DIV_WAIT: begin
                    if (!div_busy) begin
                        r_period <= div_quo;
                    end
                end
                llrg_pkg::S_SET_FIN: begin
                    r_goal   <= r_lvl;
                    r_tleft  <= r_ttime;
                    r_wait   <= TIME_W'(r_delay);
                    r_active <= 1'b1;
                end
                llrg_pkg::S_TICK: begin
                    if (r_active) begin
                        if (r_wait > TIME_W'(1)) begin
                            r_wait <= r_wait - TIME_W'(1);
                        end else begin
                            r_tleft <= tleft_sub;
                        end
                    end
                end
                llrg_pkg::S_FIRE: begin
                    if (fire_end) begin
                        r_now    <= r_goal;
                        r_tleft  <= '0;
                        r_active <= 1'b0;
                        r_wait   <= '0;
                    end else begin
                        if (r_goal > r_now) begin
                            r_now <= r_now + LVL_W'(STEP_SIZE);
                        end else begin
                            r_now <= r_now - LVL_W'(STEP_SIZE);
                        end
                        r_wait <= r_period;
                    end
                end
                default: begin
                    r_wait <= r_wait;
                end
            endcase
        end
    end

    // Item fields and per-item flags
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_act   <= s_axis_tuser;
            r_lvl   <= s_axis_tdata[15:0];
            r_ttime <= s_axis_tdata[41:16];
            r_delay <= s_axis_tdata[52:42];
            r_wrote <= 1'b0;
            r_done  <= 1'b0;
        end else if (r_state == llrg_pkg::S_TICK && r_active && r_wait <= TIME_W'(1)) begin
            r_wrote <= 1'b1;
        end else if (r_state == llrg_pkg::S_FIRE) begin
            r_done <= fire_end;
        end
        if (r_state == llrg_pkg::S_STEPS) begin
            r_steps <= steps_calc;
        end
    end

    assign drive_val = llrg_pkg::clamp_level(r_now, r_rmin, r_rmax);

    always_comb begin
        case (r_act)
            llrg_pkg::ACT_SET:  now_out = (r_ttime != '0) ? r_now : r_goal;
            llrg_pkg::ACT_TICK: now_out = r_now;
            default:            now_out = drive_val;
        endcase
    end

    // Output register: hold the transaction until the downstream side takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (out_load) begin
            r_out_data <= {4'b0, r_done, r_tleft, r_goal, now_out, r_wrote, drive_val};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire

// ===== src/llrg_checker.sv =====
// Port-level checker for light_level_ramp_generator_core, attached by bind.
// Depends on llrg_pkg for port widths and the action codes.
`timescale 1ns / 1ps
`default_nettype none

module llrg_checker (
    input wire                             i_clk,
    input wire                             i_rst_n,
    input wire [llrg_pkg::ACT_W-1:0]       s_axis_tuser,
    input wire                             s_axis_tvalid,
    input wire                             s_axis_tready,
    input wire                             m_axis_tvalid,
    input wire                             m_axis_tready,
    input wire [llrg_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

    // Stalled output transaction stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output transaction dropped while stalled");

    // One item at a time: input closes right after an accept, unless the item is dropped.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser != llrg_pkg::ACT_NONE)
            |=> !s_axis_tready)
        else $error("input accepted while an item is in work");

    // Completion only comes with a drive write.
    a_done_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[75] |-> m_axis_tdata[16])
        else $error("ramp done without drive write");

    // Completion reports the level at its goal and no time left.
    a_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[75] |->
            m_axis_tdata[74:49] == '0 && m_axis_tdata[32:17] == m_axis_tdata[48:33])
        else $error("ramp done with level off goal or time left");

endmodule

bind light_level_ramp_generator_core llrg_checker u_llrg_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
